// ===== hdl/raster_grow_cross_dilation_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the raster grow block
// Short forms of the concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef RASTER_GROW_CROSS_DILATION_MACROS_SVH
`define RASTER_GROW_CROSS_DILATION_MACROS_SVH

// General form: explicit clock and active-low reset.
`define RGCD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Form for modules that use the standard clk_i / rst_ni names.
`define RGCD_ASSERT_CLK(name, prop, msg) `RGCD_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/rgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgcd_pkg
// Shared widths, reset values and codes of the raster grow block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgcd_pkg;

  localparam int MAX_COLS_DEF   = 4096;
  localparam int PIXEL_BITS_DEF = 32;

  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int FRAME_WIDTH_W  = 13;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int CELL_W         = 32;
  localparam int OUT_W          = 31;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 13'd4096;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_BINARY_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

endpackage

`default_nettype wire

// ===== hdl/raster_grow_cross_dilation.sv =====
// ----------------------------------------------------------------------------
// raster_grow_cross_dilation
// Grows the positive areas of a raster frame by one cell (4-connected cross).
// ----------------------------------------------------------------------------
// Cells arrive in raster order, one word per clock at full rate, and each
// result leaves one row after its input row, when the cell below it arrives;
// the last row is pushed out by drain words, one result per drain word. An
// accepted word's result is registered in the output register, or in the skid
// register if the output is stalled. The sustained rate is one word per cycle
// unless the output stalls, set by the two line stores: every cycle each store
// is read at the column that comes next and its right neighbor while the
// current cell is written, and a word just written is forwarded to a read of
// the same entry in the following cycle. The two-word output stage lets the
// input keep flowing until the skid register fills. The line stores have no
// reset and need no clearing pass; words are taken directly after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_grow_cross_dilation #(
  parameter int MAX_COLS   = rgcd_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = rgcd_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [rgcd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [rgcd_pkg::CFG_DATA_W-1:0]   cfg_data_i,

  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic signed [rgcd_pkg::CELL_W-1:0] cell_value_i,

  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rgcd_pkg::OUT_W-1:0]        out_value_o,
  output logic                              frame_end_o
);

  import rgcd_pkg::*;

  localparam int ColW = $clog2(MAX_COLS);

  // Configuration registers.
  logic [FRAME_WIDTH_W-1:0]  frame_width_q;
  logic [FRAME_HEIGHT_W-1:0] frame_height_q;
  logic                      binary_mode_q;

  // Scan position and phase.
  logic [ColW-1:0]           col_q, col_d;
  logic [FRAME_HEIGHT_W-1:0] row_q, row_d;
  logic                      sel_q, sel_d;      // store receiving the incoming row
  logic                      drain_q, drain_d;  // emitting the last row

  // Effective frame size and position flags.
  logic [31:0]               w_eff;
  logic [FRAME_HEIGHT_W:0]   h_eff;
  logic                      last_col;
  logic                      last_row;

  // Handshake and step decode.
  logic                      in_acc;
  logic                      is_drain;
  logic                      step_pix;
  logic                      step_drn;
  logic                      step;

  logic signed [PIXEL_BITS-1:0] pix_v;

  // Line store ports.
  logic [ColW-1:0]           rd_addr0, rd_addr1;
  logic [PIXEL_BITS-1:0]     a_rd0, a_rd1, b_rd0, b_rd1;
  logic [PIXEL_BITS-1:0]     a0, a1, b0, b1;

  // Forwarding of the word written in the previous cycle.
  logic                      fwd_we_q;
  logic                      fwd_sel_q;
  logic [ColW-1:0]           fwd_addr_q;
  logic [PIXEL_BITS-1:0]     fwd_data_q;
  logic [ColW-1:0]           rd0_q, rd1_q;

  // Neighborhood of the cell being judged.
  logic signed [PIXEL_BITS-1:0] inc_val, mid_c, mid_r;
  logic signed [PIXEL_BITS-1:0] left_q;
  logic                      has_up;

  // Result and output stage.
  logic                      res_v;
  logic [OUT_W-1:0]          res_value;
  logic                      res_end;
  logic                      out_fire;
  logic                      out_v_q, skid_v_q;
  logic [OUT_W-1:0]          out_val_q, skid_val_q;
  logic                      out_end_q, skid_end_q;

  function automatic logic is_pos(input logic signed [PIXEL_BITS-1:0] x);
    return !x[PIXEL_BITS-1] && (x != '0);
  endfunction

  // Judges the middle cell against its cross neighbors.
  function automatic logic [OUT_W-1:0] judge(
    input logic signed [PIXEL_BITS-1:0] mid,
    input logic signed [PIXEL_BITS-1:0] left,
    input logic signed [PIXEL_BITS-1:0] right,
    input logic signed [PIXEL_BITS-1:0] up,
    input logic signed [PIXEL_BITS-1:0] below,
    input logic                         left_ok,
    input logic                         right_ok,
    input logic                         up_ok,
    input logic                         below_ok,
    input logic                         bin
  );
    logic signed [63:0] m64;
    logic [OUT_W-1:0]   r;
    m64 = 64'(mid);
    if (is_pos(mid)) begin
      if (bin) begin
        r = OUT_W'(1);
      end else if (m64 > 64'sh7FFF_FFFF) begin
        r = '1;
      end else begin
        r = m64[OUT_W-1:0];
      end
    end else if (mid[PIXEL_BITS-1]) begin
      r = '0;
    end else if ((left_ok && is_pos(left)) || (right_ok && is_pos(right)) ||
                 (up_ok && is_pos(up)) || (below_ok && is_pos(below))) begin
      r = OUT_W'(1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      binary_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FRAME_WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        CFG_BINARY_MODE:  binary_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The width is used clamped to 2..MAX_COLS, the height to at least 2.
  always_comb begin
    w_eff = 32'(frame_width_q);
    if (w_eff < 32'd2) begin
      w_eff = 32'd2;
    end
    if (w_eff > 32'(MAX_COLS)) begin
      w_eff = 32'(MAX_COLS);
    end
  end

  assign h_eff    = (frame_height_q < FRAME_HEIGHT_W'(2)) ? (FRAME_HEIGHT_W+1)'(2)
                                                          : {1'b0, frame_height_q};
  assign last_col = (32'(col_q) + 32'd1) >= w_eff;
  assign last_row = ((FRAME_HEIGHT_W+1)'(row_q) + (FRAME_HEIGHT_W+1)'(1)) >= h_eff;

  // --------------------------------------------------------------------------
  // Step decode: a pixel while draining and a drain word while loading are
  // taken but change nothing.
  // --------------------------------------------------------------------------
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_drain   = (op_e'(op_i) == OP_DRAIN);
  assign step_pix   = in_acc && !is_drain && !drain_q;
  assign step_drn   = in_acc && is_drain && drain_q;
  assign step       = step_pix || step_drn;

  // Cells wider than the field keep their low bits; narrower ones sign extend.
  assign pix_v = PIXEL_BITS'(cell_value_i);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sel_d   = sel_q;
    drain_d = drain_q;
    if (step_pix) begin
      if (last_col) begin
        col_d = '0;
        sel_d = !sel_q;
        if (last_row) begin
          drain_d = 1'b1;
        end else begin
          row_d = row_q + FRAME_HEIGHT_W'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end else if (step_drn) begin
      if (last_col) begin
        col_d   = '0;
        row_d   = '0;
        drain_d = 1'b0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sel_q   <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sel_q   <= sel_d;
      drain_q <= drain_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line stores. Both are read at the next column and its right neighbor, so
  // the data for the current position is ready when the cycle starts. The
  // right neighbor of the last possible column is masked, so its address
  // wraps to zero rather than leaving the store.
  // --------------------------------------------------------------------------
  assign rd_addr0 = col_d;
  assign rd_addr1 = (col_d == ColW'(MAX_COLS - 1)) ? '0 : col_d + ColW'(1);

  rgcd_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_store_a (
    .clk_i    (clk_i),
    .we_i     (step_pix && !sel_q),
    .waddr_i  (col_q),
    .wdata_i  (pix_v),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  rgcd_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_store_b (
    .clk_i    (clk_i),
    .we_i     (step_pix && sel_q),
    .waddr_i  (col_q),
    .wdata_i  (pix_v),
    .raddr0_i (rd_addr0),
    .raddr1_i (rd_addr1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  // The stores return the old word on a same-cycle read and write. This
  // happens when a row ends in a narrow frame and the row just written
  // becomes the middle row at once, so the written word is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_we_q <= 1'b0;
    end else begin
      fwd_we_q <= step_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_sel_q  <= sel_q;
    fwd_addr_q <= col_q;
    fwd_data_q <= pix_v;
    rd0_q      <= rd_addr0;
    rd1_q      <= rd_addr1;
  end

  assign a0 = (fwd_we_q && !fwd_sel_q && (fwd_addr_q == rd0_q)) ? fwd_data_q : a_rd0;
  assign a1 = (fwd_we_q && !fwd_sel_q && (fwd_addr_q == rd1_q)) ? fwd_data_q : a_rd1;
  assign b0 = (fwd_we_q && fwd_sel_q && (fwd_addr_q == rd0_q)) ? fwd_data_q : b_rd0;
  assign b1 = (fwd_we_q && fwd_sel_q && (fwd_addr_q == rd1_q)) ? fwd_data_q : b_rd1;

  // The incoming store still holds the row above the middle row at this
  // column, since the new cell is written only at the end of this cycle.
  assign inc_val = sel_q ? b0 : a0;
  assign mid_c   = sel_q ? a0 : b0;
  assign mid_r   = sel_q ? a1 : b1;

  // The left neighbor is the middle cell judged in the previous step.
  always_ff @(posedge clk_i) begin
    if (step) begin
      left_q <= mid_c;
    end
  end

  // --------------------------------------------------------------------------
  // Result. The row above exists from the third input row on and always
  // while draining; the row below exists only for pixel words.
  // --------------------------------------------------------------------------
  assign has_up    = step_drn || (row_q >= FRAME_HEIGHT_W'(2));
  assign res_v     = (step_pix && (row_q != '0)) || step_drn;
  assign res_end   = step_drn && last_col;
  assign res_value = judge(mid_c, left_q, mid_r, inc_val, pix_v,
                           col_q != '0, !last_col, has_up, !is_drain,
                           binary_mode_q);

  // --------------------------------------------------------------------------
  // Output register with skid register. The input is stalled only while the
  // skid register is full, which needs a stalled output word ahead of it.
  // --------------------------------------------------------------------------
  assign out_fire = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_fire || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= res_v;
      end
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_v_q) begin
      if (skid_v_q) begin
        out_val_q <= skid_val_q;
        out_end_q <= skid_end_q;
      end else begin
        out_val_q <= res_value;
        out_end_q <= res_end;
      end
    end else if (res_v) begin
      skid_val_q <= res_value;
      skid_end_q <= res_end;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_value_o = out_val_q;
  assign frame_end_o = out_end_q;

endmodule

`default_nettype wire

// ===== hdl/rgcd_ram.sv =====
// ----------------------------------------------------------------------------
// rgcd_ram
// Generic synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rgcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read-first: a read of the entry being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

// ===== hdl/rgcd_checker.sv =====
// ----------------------------------------------------------------------------
// rgcd_checker
// Port-level checks of the raster grow block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raster_grow_cross_dilation_macros.svh"

module rgcd_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [rgcd_pkg::OUT_W-1:0] out_value_o,
  input  logic                       frame_end_o
);

  // A stalled output word stays and holds its payload.
  `RGCD_ASSERT_CLK(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_value_o) && $stable(frame_end_o)), "output word changed while stalled")

  // The input is held back only while an output word waits.
  `RGCD_ASSERT_CLK(a_stall_needs_word, in_stall_o |-> out_valid_o, "input stalled with empty output")

  // Once the waiting word is taken, the input opens again.
  `RGCD_ASSERT_CLK(a_stall_release, (in_stall_o && !out_stall_i) |=> !in_stall_o, "input stall outlived output stall")

  // A new output word follows an accepted input word.
  `RGCD_ASSERT_CLK(a_no_invented_word, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o), "output word without input")

endmodule

bind raster_grow_cross_dilation rgcd_checker u_rgcd_checker (.*);

`default_nettype wire

// ===== verif/raster_grow_result_checker.sv =====
// ----------------------------------------------------------------------------
// Result checker for the raster grow block
// Watches the configuration port and both word channels, keeps its own copy
// of the line stores and counters, and compares every result word against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_grow_result_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgcd_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [rgcd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                op_i,
  input  logic signed [rgcd_pkg::CELL_W-1:0]  cell_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [rgcd_pkg::OUT_W-1:0]          out_value_i,
  input  logic                                frame_end_i,
  output int                                  mismatch_count_o,
  output int                                  pending_cells_o,
  output int                                  checked_cells_o
);

  import rgcd_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             frame_end;
  } grown_cell_t;

  grown_cell_t              expected_cells[$];
  grown_cell_t              oldest;

  // Two row stores; fill_sel picks the one taking the incoming row, the other
  // one holds the row being judged.
  logic signed [CELL_W-1:0] line_mem [2][MAX_COLS_DEF];
  logic                     fill_sel;
  int unsigned              col_pos;
  int unsigned              row_pos;
  logic                     draining;

  logic [FRAME_WIDTH_W-1:0]  cfg_width;
  logic [FRAME_HEIGHT_W-1:0] cfg_height;
  logic                      cfg_binary;

  function automatic logic [OUT_W-1:0] grown_value(logic mid_sel, logic has_up,
      logic signed [CELL_W-1:0] below, logic has_below, int unsigned c, int unsigned w);
    logic signed [CELL_W-1:0] mid_cell;
    mid_cell = line_mem[mid_sel][c];
    if (mid_cell > 0) return cfg_binary ? OUT_W'(1) : OUT_W'(mid_cell);
    if (mid_cell < 0) return '0;
    if ((c > 0 && line_mem[mid_sel][c-1] > 0) ||
        (c + 1 < w && line_mem[mid_sel][c+1] > 0) ||
        (has_up && line_mem[!mid_sel][c] > 0) ||
        (has_below && below > 0)) return OUT_W'(1);
    return '0;
  endfunction

  task automatic predict_word(op_e op, logic signed [CELL_W-1:0] pixel);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    logic        last_col;
    w = (cfg_width < 2) ? 2 : (cfg_width > MAX_COLS_DEF) ? MAX_COLS_DEF : cfg_width;
    h = (cfg_height < 2) ? 2 : cfg_height;
    c = (col_pos >= MAX_COLS_DEF) ? MAX_COLS_DEF - 1 : col_pos;
    last_col = (c + 1 >= w);
    if (op == OP_PIXEL) begin
      if (draining) return;
      // The first row only fills a store; every later pixel releases the cell above it.
      if (row_pos >= 1)
        expected_cells.push_back({grown_value(!fill_sel, row_pos >= 2, pixel, 1'b1, c, w),
                                  1'b0});
      line_mem[fill_sel][c] = pixel;
      if (last_col) begin
        col_pos = 0;
        fill_sel = !fill_sel;
        if (row_pos + 1 >= h) draining = 1'b1;
        else row_pos = row_pos + 1;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      if (!draining) return;
      expected_cells.push_back({grown_value(!fill_sel, 1'b1, '0, 1'b0, c, w), last_col});
      if (last_col) begin
        col_pos = 0;
        row_pos = 0;
        draining = 1'b0;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      expected_cells.delete();
      fill_sel = 1'b0;
      col_pos = 0;
      row_pos = 0;
      draining = 1'b0;
      cfg_width = FRAME_WIDTH_RST;
      cfg_height = FRAME_HEIGHT_RST;
      cfg_binary = 1'b0;
      pending_cells_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result word: out_value %0h frame_end %0b",
                 out_value_i, frame_end_i);
          mismatch_count_o++;
        end else begin
          oldest = expected_cells.pop_front();
          checked_cells_o++;
          if (out_value_i !== oldest.value) begin
            $error("out_value: expected %0h, got %0h", oldest.value, out_value_i);
            mismatch_count_o++;
          end
          if (frame_end_i !== oldest.frame_end) begin
            $error("frame_end: expected %0b, got %0b", oldest.frame_end, frame_end_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  cfg_width = cfg_data_i[FRAME_WIDTH_W-1:0];
          CFG_FRAME_HEIGHT: cfg_height = cfg_data_i[FRAME_HEIGHT_W-1:0];
          CFG_BINARY_MODE:  cfg_binary = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_word(op_e'(op_i), cell_value_i);
      pending_cells_o = expected_cells.size();
    end
  end

endmodule

// ===== verif/raster_grow_cross_dilation_test.sv =====
// ----------------------------------------------------------------------------
// Testbench for raster_grow_cross_dilation
// Streams directed and random raster frames through the block under three
// handshake idling profiles; a checker beside the block predicts every grown
// cell and compares it with the result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_grow_cross_dilation_test;
  import rgcd_pkg::*;

  // Cycles without any accepted word or register write before the run is
  // declared hung. Realistic stall runs stay far below this.
  localparam int STALL_LIMIT   = 1000;
  // Cycles allowed for the pipeline to settle once nothing is outstanding;
  // pixels of the first row produce no result, so they may still be in
  // flight when the last expected word has left.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 16;
  // Percentage of well-formed words preceded by a word the block must ignore.
  localparam int NOISE_PCT     = 4;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      op_i = 1'b0;
  logic signed [CELL_W-1:0]  cell_value_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [OUT_W-1:0]          out_value_o;
  logic                      frame_end_o;

  int mismatch_count;
  int pending_cells;
  int checked_cells;

  int send_idle_pct;
  int recv_idle_pct;
  int words_sent;
  int noise_words;
  int frames_run;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  raster_grow_cross_dilation DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .cell_value_i (cell_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .frame_end_o  (frame_end_o)
  );

  raster_grow_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .cell_value_i     (cell_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_value_i      (out_value_o),
    .frame_end_i      (frame_end_o),
    .mismatch_count_o (mismatch_count),
    .pending_cells_o  (pending_cells),
    .checked_cells_o  (checked_cells)
  );

  // The receiver stalls independently of everything else, so stalls land on
  // every phase of the block's work, including while results back up.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: counts cycles in which neither channel moves a word and no
  // register is written. A hang anywhere, including results that never
  // arrive, ends the run here.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[raster_grow_cross_dilation] ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high afterwards; the next call either replaces the payload or drops
  // valid for an idle gap, so valid gets one assignment per time step.
  task automatic send_word(op_e op, logic [CELL_W-1:0] value, bit noise);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    cell_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (noise) noise_words++;
    else words_sent++;
  endtask

  // Registers may only change while nothing is in flight. The first edge
  // lets the checker book the last accepted word before its count is read.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cells != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write enable is left high; the caller lowers it after a group of writes.
  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // The unused upper data bits are randomized; the block must drop them.
  task automatic configure(int w_raw, int h_raw, bit binary);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'($urandom);
    data[FRAME_WIDTH_W-1:0] = FRAME_WIDTH_W'(w_raw);
    cfg_write(CFG_FRAME_WIDTH, data);
    cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(h_raw));
    data = CFG_DATA_W'($urandom);
    data[0] = binary;
    cfg_write(CFG_BINARY_MODE, data);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly zero, negative and small positive cells so that growth, blocking
  // and pass-through all occur often; full-range words exercise every bit.
  function automatic logic [CELL_W-1:0] random_cell();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return '0;
    if (pick < 60) return $urandom | 32'h8000_0000;
    if (pick < 85) return $urandom_range(1, 255);
    return $urandom;
  endfunction

  // One well-formed frame: all pixels, then one drain word per column.
  // Drain words slipped in while loading and pixels slipped in while
  // draining must both be ignored by the block.
  task automatic send_grow_frame(int cols, int rows_n);
    for (int r = 0; r < rows_n; r++) begin
      for (int c = 0; c < cols; c++) begin
        if ($urandom_range(99) < NOISE_PCT) send_word(OP_DRAIN, $urandom, 1'b1);
        send_word(OP_PIXEL, random_cell(), 1'b0);
      end
    end
    for (int c = 0; c < cols; c++) begin
      if ($urandom_range(99) < NOISE_PCT) send_word(OP_PIXEL, $urandom, 1'b1);
      send_word(OP_DRAIN, $urandom, 1'b0);
    end
    frames_run++;
  endtask

  // Most frames are small; raw sizes below two check the clamp to two.
  task automatic random_frame();
    int pick;
    int w_raw;
    int h_raw;
    pick = $urandom_range(99);
    if (pick < 70) w_raw = $urandom_range(2, 8);
    else if (pick < 90) w_raw = $urandom_range(9, 32);
    else if (pick < 95) w_raw = $urandom_range(0, 1);
    else w_raw = $urandom_range(33, 100);
    pick = $urandom_range(99);
    if (pick < 80) h_raw = $urandom_range(2, 5);
    else if (pick < 90) h_raw = $urandom_range(6, 12);
    else h_raw = $urandom_range(0, 1);
    configure(w_raw, h_raw, $urandom_range(1));
    send_grow_frame((w_raw < 2) ? 2 : w_raw, (h_raw < 2) ? 2 : h_raw);
  endtask

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 81;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame: three columns, height written as zero so it clamps to
    // two rows. Covers the largest and smallest cell values, growth from the
    // left, blocking by negative cells, both kinds of ignored word, and the
    // frame end on the last drain word.
    configure(3, 0, 1'b0);
    send_word(OP_DRAIN, '1, 1'b1);
    send_word(OP_PIXEL, 32'h7FFF_FFFF, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h8000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0005, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'hFFFF_FFFF, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0001, 1'b1);
    repeat (3) send_word(OP_DRAIN, '0, 1'b0);
    frames_run++;

    // Directed frame in binary mode, four columns by three rows, cut down
    // mid-frame: with the second row at column three the width drops to two,
    // so the next pixel ends the row, and the height drops to two, so that
    // row also ends loading.
    configure(4, 3, 1'b1);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h1234_5678, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    send_word(OP_PIXEL, 32'h2AAA_5555, 1'b0);
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
    cfg_we_i <= 1'b0;
    send_word(OP_PIXEL, 32'h0000_0000, 1'b0);
    repeat (2) send_word(OP_DRAIN, '0, 1'b0);
    frames_run++;

    // Random frames under the three idling profiles.
    while (words_sent < 600) random_frame();
    send_idle_pct = 81;
    recv_idle_pct = 30;
    while (words_sent < 1200) random_frame();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent < 1700) random_frame();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cells != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d frames, %0d words (%0d of them ignored), %0d grown cells checked.",
             frames_run, words_sent + noise_words, noise_words, checked_cells);
    $display("Widths 2 to 100, heights 2 to 12, both output modes, three idling profiles.");
    if (mismatch_count == 0) begin
      $display("[raster_grow_cross_dilation] OK");
    end else begin
      $display("[raster_grow_cross_dilation] ERROR");
    end
    $finish;
  end

endmodule
